// File: hdl/prab_pkg.sv
package prab_pkg;

	localparam int MAX_SAMPLES = 16384;
	localparam int POS_W       = $clog2(MAX_SAMPLES);
	localparam int CNT_W       = POS_W + 1;
	localparam int CAP_W       = 15;
	localparam int CHK_W       = 11;
	localparam int CPOS_W      = 10;
	localparam int CHUNK_MAX   = 1024;
	localparam int SAMPLE_W    = 16;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	localparam logic [CAP_W-1:0] CAP_RESET   = CAP_W'(8192);
	localparam logic [CHK_W-1:0] CHUNK_RESET = CHK_W'(512);

	// register select bit of paddr (word address)
	localparam logic REG_CAPACITY = 1'b0;
	localparam logic REG_CHUNK    = 1'b1;

	typedef enum logic [1:0] {
		OP_STORE = 2'd0,
		OP_DRAIN = 2'd1,
		OP_CLEAR = 2'd2
	} opcode_t;

	typedef enum logic {
		ST_IDLE,
		ST_RESULT
	} ctrl_state_t;

	typedef struct packed {
		logic store;
		logic drain;
		logic clear;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic               cap_wr;
		logic               chunk_wr;
		logic [PDATA_W-1:0] wdata;
	} cfg_wr_t;

endpackage

// File: hdl/prab_req_if.sv
interface prab_req_if;
	logic                                  valid;
	logic                                  ready;
	logic [1:0]                            opcode;
	logic signed [prab_pkg::SAMPLE_W-1:0]  sample_in;

	modport source (output valid, output opcode, output sample_in, input ready);
	modport sink (input valid, input opcode, input sample_in, output ready);
endinterface

// File: hdl/prab_rsp_if.sv
interface prab_rsp_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [prab_pkg::SAMPLE_W-1:0]  sample_out;
	logic                                  chunk_last;
	logic                                  drain_last;
	logic                                  empty_res;

	modport source (output valid, output sample_out, output chunk_last, output drain_last,
		output empty_res, input ready);
	modport sink (input valid, input sample_out, input chunk_last, input drain_last,
		input empty_res, output ready);
endinterface

// File: hdl/preroll_audio_ring_buffer.sv
// pre-roll ring buffer for 16-bit pcm samples
// samples channel: one request per item; opcode store writes sample_in into the
// ring (oldest entry overwritten when full, ignored mid-drain), drain asks for
// the next buffered sample, clear empties the ring and ends a drain
// drained channel: one result per drain request, oldest sample first, with
// chunk_last at every chunk_samples boundary and drain_last on the final one;
// empty_res with zero data when nothing is buffered or capacity is zero
// a drain passes the registered read port of the sample memory, then the output
// register, before its result shows; samples.ready is low while the read data
// waits in the result state for the output register
// the result sits in an output register: while the receiver stalls, stores and
// clears are still taken; a further drain is taken, then holds samples.ready low
// until the output register frees
// apb port: capacity at 0x0 (write also empties the ring), chunk size at 0x4
// reset empties the ring and loads capacity 8192, chunk 512; memory contents
// are not cleared, only written entries are ever read
module preroll_audio_ring_buffer (
	input  logic                            clk,
	input  logic                            arst_n,
	prab_req_if.sink                        samples,
	prab_rsp_if.source                      drained,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [prab_pkg::PADDR_W-1:0]    paddr,
	input  logic [prab_pkg::PDATA_W-1:0]    pwdata,
	output logic [prab_pkg::PDATA_W-1:0]    prdata,
	output logic                            pready
);

	prab_pkg::ctrl_cmd_t            cmd;
	prab_pkg::cfg_wr_t              cfg;
	logic                           rsp_free;
	logic                           req_ready;
	logic                           apb_wr;
	logic [prab_pkg::CAP_W-1:0]     capacity_q;
	logic [prab_pkg::CHK_W-1:0]     chunk_q;

	assign pready       = 1'b1;
	assign apb_wr       = psel && penable && pwrite && pready;
	assign cfg.cap_wr   = apb_wr && (paddr[2] == prab_pkg::REG_CAPACITY);
	assign cfg.chunk_wr = apb_wr && (paddr[2] == prab_pkg::REG_CHUNK);
	assign cfg.wdata    = pwdata;

	always_comb begin
		case (paddr[2])
			prab_pkg::REG_CAPACITY: prdata = prab_pkg::PDATA_W'(capacity_q);
			prab_pkg::REG_CHUNK:    prdata = prab_pkg::PDATA_W'(chunk_q);
			default:                prdata = '0;
		endcase
	end

	prab_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (samples.valid),
		.opcode    (samples.opcode),
		.rsp_free  (rsp_free),
		.req_ready (req_ready),
		.cmd       (cmd)
	);

	assign samples.ready = req_ready;

	prab_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg        (cfg),
		.sample_in  (samples.sample_in),
		.rsp_ready  (drained.ready),
		.rsp_free   (rsp_free),
		.rsp_valid  (drained.valid),
		.sample_out (drained.sample_out),
		.chunk_last (drained.chunk_last),
		.drain_last (drained.drain_last),
		.empty_res  (drained.empty_res),
		.capacity_q (capacity_q),
		.chunk_q    (chunk_q)
	);

`ifndef SYNTH
	// an accepted drain blocks the next request for the memory read cycle
	a_drain_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		samples.valid && samples.ready && (samples.opcode == prab_pkg::OP_DRAIN)
		|=> !samples.ready)
		else $error("request accepted right after a drain");

	// a new result only appears out of the result state
	a_rise_from_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(drained.valid) |-> $past(!samples.ready))
		else $error("result loaded outside the result state");

	a_empty_clean: assert property (@(posedge clk) disable iff (!arst_n)
		drained.valid && drained.empty_res |->
		(drained.sample_out == '0) && !drained.chunk_last && !drained.drain_last)
		else $error("empty result carries data or marks");

	a_last_closes_chunk: assert property (@(posedge clk) disable iff (!arst_n)
		drained.valid && drained.drain_last |-> drained.chunk_last)
		else $error("final sample does not close its chunk");
`endif

endmodule

// File: hdl/prab_ctrl.sv
module prab_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic [1:0]          opcode,
	input  logic                rsp_free,
	output logic                req_ready,
	output prab_pkg::ctrl_cmd_t cmd
);

	prab_pkg::ctrl_state_t state_q, state_d;
	logic                  accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prab_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		req_ready    = 1'b0;
		accept       = 1'b0;
		cmd          = '0;
		case (state_q)
			prab_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				accept    = req_valid;
				case (opcode)
					prab_pkg::OP_STORE: cmd.store = accept;
					prab_pkg::OP_CLEAR: cmd.clear = accept;
					prab_pkg::OP_DRAIN: begin
						cmd.drain = accept;
						if (accept) state_d = prab_pkg::ST_RESULT;
					end
					default: ;
				endcase
			end
			prab_pkg::ST_RESULT: begin
				// read data is registered, hand it to the output stage once it frees up
				if (rsp_free) begin
					cmd.load_out = 1'b1;
					state_d      = prab_pkg::ST_IDLE;
				end
			end
			default: state_d = prab_pkg::ST_IDLE;
		endcase
	end

endmodule

// File: hdl/prab_dp.sv
module prab_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  prab_pkg::ctrl_cmd_t                   cmd,
	input  prab_pkg::cfg_wr_t                     cfg,
	input  logic signed [prab_pkg::SAMPLE_W-1:0]  sample_in,
	input  logic                                  rsp_ready,
	output logic                                  rsp_free,
	output logic                                  rsp_valid,
	output logic signed [prab_pkg::SAMPLE_W-1:0]  sample_out,
	output logic                                  chunk_last,
	output logic                                  drain_last,
	output logic                                  empty_res,
	output logic [prab_pkg::CAP_W-1:0]            capacity_q,
	output logic [prab_pkg::CHK_W-1:0]            chunk_q
);

	localparam int POS_W  = prab_pkg::POS_W;
	localparam int CNT_W  = prab_pkg::CNT_W;
	localparam int CHK_W  = prab_pkg::CHK_W;
	localparam int CPOS_W = prab_pkg::CPOS_W;
	localparam int SW     = prab_pkg::SAMPLE_W;

	logic signed [SW-1:0] sample_store_q [prab_pkg::MAX_SAMPLES];

	logic [POS_W-1:0]  write_pos_q, read_pos_q;
	logic [CNT_W-1:0]  fill_q, remaining_q;
	logic [CPOS_W-1:0] chunk_pos_q;
	logic              draining_q;

	logic signed [SW-1:0] rdata_s1;
	logic                 empty_s1, clast_s1, dlast_s1;
	logic                 out_valid_q;
	logic signed [SW-1:0] out_sample_q;
	logic                 out_clast_q, out_dlast_q, out_empty_q;

	logic [CNT_W-1:0]  cap_eff;
	logic [CHK_W-1:0]  chunk_eff;
	logic [POS_W-1:0]  wp_use, wp_next, start_pos, cur_rp, rp_next;
	logic [CNT_W-1:0]  wp_inc, rp_inc, cur_rem, rem_next;
	logic [CNT_W:0]    wp_wide;
	logic [CHK_W-1:0]  cpos_next;
	logic              empty_now, dlast, clast, store_ok;

	always_comb begin
		if (32'(capacity_q) > 32'(prab_pkg::MAX_SAMPLES)) begin
			cap_eff = CNT_W'(prab_pkg::MAX_SAMPLES);
		end else begin
			cap_eff = CNT_W'(capacity_q);
		end
		if (chunk_q == '0) begin
			chunk_eff = CHK_W'(1);
		end else if (32'(chunk_q) > 32'(prab_pkg::CHUNK_MAX)) begin
			chunk_eff = CHK_W'(prab_pkg::CHUNK_MAX);
		end else begin
			chunk_eff = chunk_q;
		end

		wp_use   = (CNT_W'(write_pos_q) >= cap_eff) ? '0 : write_pos_q;
		wp_inc   = CNT_W'(wp_use) + CNT_W'(1);
		wp_next  = (wp_inc >= cap_eff) ? '0 : wp_inc[POS_W-1:0];
		store_ok = (cap_eff != '0) && !draining_q;

		// oldest sample sits fill_count behind the write position, modulo capacity
		if (CNT_W'(write_pos_q) >= fill_q) begin
			wp_wide = (CNT_W+1)'(write_pos_q) - (CNT_W+1)'(fill_q);
		end else begin
			wp_wide = (CNT_W+1)'(write_pos_q) + (CNT_W+1)'(cap_eff) - (CNT_W+1)'(fill_q);
		end
		start_pos = wp_wide[POS_W-1:0];

		empty_now = !draining_q && ((cap_eff == '0) || (fill_q == '0));
		cur_rp    = draining_q ? read_pos_q : start_pos;
		cur_rem   = draining_q ? remaining_q : fill_q;
		rp_inc    = CNT_W'(cur_rp) + CNT_W'(1);
		rp_next   = (rp_inc >= cap_eff) ? '0 : rp_inc[POS_W-1:0];
		rem_next  = cur_rem - CNT_W'(1);
		cpos_next = (draining_q ? CHK_W'(chunk_pos_q) : '0) + CHK_W'(1);
		dlast     = (rem_next == '0);
		clast     = dlast || (cpos_next >= chunk_eff);
	end

	// sample memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.store && store_ok) begin
			sample_store_q[wp_use] <= sample_in;
		end
		if (cmd.drain) begin
			rdata_s1 <= sample_store_q[cur_rp];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.drain) begin
			empty_s1 <= empty_now;
			clast_s1 <= !empty_now && clast;
			dlast_s1 <= !empty_now && dlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= prab_pkg::CAP_RESET;
			chunk_q    <= prab_pkg::CHUNK_RESET;
		end else begin
			if (cfg.cap_wr) capacity_q <= cfg.wdata[prab_pkg::CAP_W-1:0];
			if (cfg.chunk_wr) chunk_q <= cfg.wdata[CHK_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_pos_q <= '0;
			read_pos_q  <= '0;
			fill_q      <= '0;
			remaining_q <= '0;
			chunk_pos_q <= '0;
			draining_q  <= 1'b0;
		end else if (cfg.cap_wr || cmd.clear || (cmd.drain && !empty_now && dlast)) begin
			write_pos_q <= '0;
			read_pos_q  <= '0;
			fill_q      <= '0;
			remaining_q <= '0;
			chunk_pos_q <= '0;
			draining_q  <= 1'b0;
		end else if (cmd.store && store_ok) begin
			write_pos_q <= wp_next;
			if (fill_q < cap_eff) fill_q <= fill_q + CNT_W'(1);
		end else if (cmd.drain && !empty_now) begin
			read_pos_q  <= rp_next;
			remaining_q <= rem_next;
			chunk_pos_q <= clast ? '0 : cpos_next[CPOS_W-1:0];
			draining_q  <= 1'b1;
		end
	end

	// output register, decouples the receiver from the ring
	assign rsp_free = !out_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_sample_q <= empty_s1 ? '0 : rdata_s1;
			out_clast_q  <= clast_s1;
			out_dlast_q  <= dlast_s1;
			out_empty_q  <= empty_s1;
		end
	end

	assign rsp_valid  = out_valid_q;
	assign sample_out = out_sample_q;
	assign chunk_last = out_clast_q;
	assign drain_last = out_dlast_q;
	assign empty_res  = out_empty_q;

endmodule
